FILE: sv/rle_pkg.sv
// Shared types and constants for the run/literal byte encoder.
// Holds the command format passed from the front end to the back end
// and the literal buffer write port. No dependencies.
`default_nettype none

package rle_pkg;

	localparam int CNT_W  = 6;
	localparam int BYTE_W = 8;

	// Run headers carry this offset on top of the run length minus one.
	localparam logic [BYTE_W-1:0] RUN_BASE = 8'd128;

	typedef enum logic [1:0] {
		SEG_NONE = 2'd0,
		SEG_RUN  = 2'd1,
		SEG_LIT  = 2'd2
	} seg_kind_t;

	// One coded chunk. For a run, len is the run length and data the byte.
	// For a literal, len bytes come from the buffer, then data if tail is set.
	typedef struct packed {
		seg_kind_t         kind;
		logic [CNT_W-1:0]  len;
		logic              tail;
		logic [BYTE_W-1:0] data;
	} seg_t;

	// All the chunks closed by one input item, in output order.
	typedef struct packed {
		seg_t a;
		seg_t b;
	} cmd_t;

	typedef struct packed {
		logic              en;
		logic [CNT_W-1:0]  addr;
		logic [BYTE_W-1:0] data;
	} buf_wr_t;

endpackage

`default_nettype wire

FILE: sv/rle_front.sv
// Front end of the run/literal encoder: accepts bytes, tracks the open
// chunk and turns closed chunks into commands for the back end.
// Depends on rle_pkg.
`default_nettype none

module rle_front #(
	parameter int MAX_CHUNK = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic [7:0]        data_byte,
	input  logic              stream_end,
	input  logic              q_full,
	input  logic              lit_done,
	output logic              cmd_push,
	output rle_pkg::cmd_t     cmd,
	output rle_pkg::buf_wr_t  buf_wr,
	output logic              lit_busy
);
	import rle_pkg::*;

	localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_CHUNK);

	typedef enum logic [1:0] {
		MODE_NEW = 2'd0,
		MODE_RUN = 2'd1,
		MODE_LIT = 2'd2
	} mode_t;

	mode_t             mode_q, mode_n;
	logic [CNT_W-1:0]  cnt_q, cnt_n, cnt_inc;
	logic [BYTE_W-1:0] prev_q, prev_n;
	logic              have_q, have_n;
	logic              busy_q;
	logic              accept;
	logic              same;
	logic              lit_set;
	seg_t              seg_a, seg_b, seg_end;

	always_comb begin
		same    = (data_byte == prev_q);
		cnt_inc = cnt_q + 1'b1;
		mode_n  = mode_q;
		cnt_n   = cnt_q;
		prev_n  = prev_q;
		have_n  = have_q;
		seg_a   = '0;
		seg_b   = '0;
		seg_end = '0;
		buf_wr  = '0;

		unique case (mode_q)
			MODE_RUN: begin
				if (same && (cnt_q < MAX_CNT)) begin
					cnt_n = cnt_inc;
				end else begin
					seg_a.kind = SEG_RUN;
					seg_a.len  = cnt_q;
					seg_a.data = prev_q;
					mode_n     = MODE_NEW;
					cnt_n      = '0;
					prev_n     = data_byte;
					have_n     = 1'b1;
				end
			end
			MODE_LIT: begin
				have_n = 1'b1;
				if (same) begin
					// A repeat of the newest byte closes the stretch without it.
					seg_a.kind = SEG_LIT;
					seg_a.len  = cnt_q;
					mode_n     = MODE_RUN;
					cnt_n      = CNT_W'(2);
				end else begin
					buf_wr.en   = 1'b1;
					buf_wr.addr = cnt_q;
					buf_wr.data = prev_q;
					cnt_n       = cnt_inc;
					prev_n      = data_byte;
					if (cnt_inc >= MAX_CNT) begin
						seg_a.kind = SEG_LIT;
						seg_a.len  = cnt_inc;
						mode_n     = MODE_NEW;
						cnt_n      = '0;
					end
				end
			end
			default: begin
				mode_n = MODE_NEW;
				if (!have_q) begin
					prev_n = data_byte;
					have_n = 1'b1;
				end else if (same) begin
					mode_n = MODE_RUN;
					cnt_n  = CNT_W'(2);
				end else begin
					buf_wr.en   = 1'b1;
					buf_wr.addr = '0;
					buf_wr.data = prev_q;
					cnt_n       = CNT_W'(1);
					mode_n      = MODE_LIT;
					prev_n      = data_byte;
				end
			end
		endcase

		// The closing chunk at end of stream; the pending byte rides as a
		// tail so a literal never needs two buffer writes in one item.
		unique case (mode_n)
			MODE_RUN: begin
				seg_end.kind = SEG_RUN;
				seg_end.len  = cnt_n;
				seg_end.data = prev_n;
			end
			MODE_LIT: begin
				seg_end.kind = SEG_LIT;
				seg_end.len  = cnt_n;
				seg_end.tail = 1'b1;
				seg_end.data = prev_n;
			end
			default: begin
				if (have_n) begin
					seg_end.kind = SEG_LIT;
					seg_end.tail = 1'b1;
					seg_end.data = prev_n;
				end
			end
		endcase

		if (stream_end) begin
			if (seg_a.kind == SEG_NONE) begin
				seg_a = seg_end;
			end else begin
				seg_b = seg_end;
			end
			mode_n = MODE_NEW;
			cnt_n  = '0;
			prev_n = '0;
			have_n = 1'b0;
		end

		// A new literal stretch waits until the back end has read the last one.
		item_stall = q_full || ((mode_q == MODE_NEW) && have_q && busy_q);
		accept     = item_valid && !item_stall;
		buf_wr.en  = buf_wr.en && accept;
		cmd_push   = accept && (seg_a.kind != SEG_NONE);
		cmd.a      = seg_a;
		cmd.b      = seg_b;
		lit_set    = cmd_push &&
			(((seg_a.kind == SEG_LIT) && (seg_a.len != '0)) ||
			 ((seg_b.kind == SEG_LIT) && (seg_b.len != '0)));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_NEW;
			cnt_q  <= '0;
			prev_q <= '0;
			have_q <= 1'b0;
			busy_q <= 1'b0;
		end else begin
			if (accept) begin
				mode_q <= mode_n;
				cnt_q  <= cnt_n;
				prev_q <= prev_n;
				have_q <= have_n;
			end
			if (lit_set) begin
				busy_q <= 1'b1;
			end else if (lit_done) begin
				busy_q <= 1'b0;
			end
		end
	end

	assign lit_busy = busy_q;

endmodule

`default_nettype wire

FILE: sv/rle_cmd_q.sv
// Two-entry command queue between the encoder front end and back end.
// Depends on rle_pkg.
`default_nettype none

module rle_cmd_q (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  rle_pkg::cmd_t wdata,
	input  logic          pop,
	output rle_pkg::cmd_t rdata,
	output logic          full,
	output logic          empty
);
	import rle_pkg::*;

	localparam int DEPTH = 2;

	cmd_t       entries_q [DEPTH];
	logic       wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;
	logic       do_push, do_pop;

	assign full    = (count_q == 2'(DEPTH));
	assign empty   = (count_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			case ({do_push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

FILE: sv/rle_back.sv
// Back end of the run/literal encoder: holds the literal buffer and plays
// out each command as header and data bytes through an output register.
// Depends on rle_pkg.
`default_nettype none

module rle_back #(
	parameter int MAX_CHUNK = 32
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             q_empty,
	input  rle_pkg::cmd_t    q_head,
	output logic             q_pop,
	input  rle_pkg::buf_wr_t buf_wr,
	output logic             lit_done,
	output logic             result_valid,
	input  logic             result_stall,
	output logic [7:0]       out_byte,
	output logic             is_header,
	output logic             last_of_burst
);
	import rle_pkg::*;

	localparam int AW = $clog2(MAX_CHUNK);

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_HDR  = 2'd1,
		ST_BODY = 2'd2,
		ST_DATA = 2'd3
	} state_t;

	logic [BYTE_W-1:0] mem [MAX_CHUNK];
	logic [BYTE_W-1:0] rd_data_q;
	logic              rd_en;
	logic [AW-1:0]     rd_addr;

	state_t            st_q;
	cmd_t              cmd_q;
	logic              sel_q;
	logic [CNT_W-1:0]  idx_q, idx_nx;
	logic              out_valid_q, hdr_q, last_q;
	logic [BYTE_W-1:0] out_byte_q;

	seg_t              seg;
	logic              seg_final;
	logic              can_emit;
	logic              emit_now;
	logic              body_last;
	logic              has_body;
	logic              more_segs;
	logic [BYTE_W-1:0] hdr_byte;

	always_comb begin
		seg       = sel_q ? cmd_q.b : cmd_q.a;
		more_segs = !sel_q && (cmd_q.b.kind != SEG_NONE);
		seg_final = !more_segs;
		can_emit  = !out_valid_q || !result_stall;
		// Every state but idle loads a new byte into the output register.
		emit_now  = can_emit && (st_q != ST_IDLE);
		idx_nx    = idx_q + 1'b1;
		body_last = (idx_nx == seg.len);
		has_body  = (seg.kind == SEG_LIT) && (seg.len != '0);
		if (seg.kind == SEG_RUN) begin
			hdr_byte = RUN_BASE + BYTE_W'(seg.len) - 8'd1;
		end else begin
			hdr_byte = BYTE_W'(seg.len) + BYTE_W'(seg.tail) - 8'd1;
		end

		rd_en   = 1'b0;
		rd_addr = '0;
		if (can_emit && (st_q == ST_HDR) && has_body) begin
			rd_en = 1'b1;
		end else if (can_emit && (st_q == ST_BODY) && !body_last) begin
			rd_en   = 1'b1;
			rd_addr = idx_nx[AW-1:0];
		end

		lit_done = can_emit && (st_q == ST_BODY) && body_last;
		q_pop    = (st_q == ST_IDLE) && !q_empty;
	end

	always_ff @(posedge clk) begin
		if (buf_wr.en) begin
			mem[buf_wr.addr[AW-1:0]] <= buf_wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			cmd_q       <= '0;
			sel_q       <= 1'b0;
			idx_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			hdr_q       <= 1'b0;
			last_q      <= 1'b0;
		end else begin
			if (out_valid_q && !result_stall && !emit_now) begin
				out_valid_q <= 1'b0;
			end
			unique case (st_q)
				ST_IDLE: begin
					if (!q_empty) begin
						cmd_q <= q_head;
						sel_q <= 1'b0;
						st_q  <= ST_HDR;
					end
				end
				ST_HDR: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= hdr_byte;
						hdr_q       <= 1'b1;
						last_q      <= 1'b0;
						idx_q       <= '0;
						st_q        <= has_body ? ST_BODY : ST_DATA;
					end
				end
				ST_BODY: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= rd_data_q;
						hdr_q       <= 1'b0;
						last_q      <= body_last && !seg.tail && seg_final;
						idx_q       <= idx_nx;
						if (body_last && seg.tail) begin
							st_q <= ST_DATA;
						end else if (body_last && more_segs) begin
							sel_q <= 1'b1;
							st_q  <= ST_HDR;
						end else if (body_last) begin
							st_q <= ST_IDLE;
						end
					end
				end
				ST_DATA: begin
					if (can_emit) begin
						out_valid_q <= 1'b1;
						out_byte_q  <= seg.data;
						hdr_q       <= 1'b0;
						last_q      <= seg_final;
						if (more_segs) begin
							sel_q <= 1'b1;
							st_q  <= ST_HDR;
						end else begin
							st_q <= ST_IDLE;
						end
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign result_valid  = out_valid_q;
	assign out_byte      = out_byte_q;
	assign is_header     = hdr_q;
	assign last_of_burst = last_q;

endmodule

`default_nettype wire

FILE: sv/rle_literal_run_encoder_core.sv
// Run/literal byte encoder, top level. One byte comes in per
// accepted item; stream_end marks the last byte and closes whatever chunk is
// open. A run of n equal bytes comes out as the header 128+(n-1) followed by
// the byte, and a literal stretch of n bytes as the header n-1 followed by the
// n bytes. Chunks never exceed MAX_CHUNK bytes. A byte that repeats the newest
// byte of a literal stretch closes that stretch and opens a run of two. An
// item is accepted whenever the two-entry command queue has room and no
// literal hold-off (below) applies, and most items produce no output at all.
// The back end sends one result per cycle while the receiver does not stall,
// and loads each command from the queue in its idle state, so the first
// result of an idle block is registered in the header state after the load.
// One item releases at most MAX_CHUNK+3 results, and receiver stalls hold
// them up. A byte that arrives while no chunk is open but a byte is pending
// is held off until the back end has sent the last buffered byte of the
// previous literal stretch, so it also waits on any command ahead of that
// stretch in the queue and on output stalls. A burst of results ends with
// last_of_burst set on its final byte. Depends on rle_pkg, rle_front,
// rle_cmd_q and rle_back.
`default_nettype none

module rle_literal_run_encoder_core #(
	parameter int MAX_CHUNK = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	// Input channel: one raw byte per request.
	input  logic       item_valid,
	output logic       item_stall,
	input  logic [7:0] data_byte,
	input  logic       stream_end,
	// Output channel: one encoded byte per request.
	output logic       result_valid,
	input  logic       result_stall,
	output logic [7:0] out_byte,
	output logic       is_header,
	output logic       last_of_burst
);
	import rle_pkg::*;

	cmd_t    cmd, q_head;
	buf_wr_t buf_wr;
	logic    cmd_push, q_pop, q_full, q_empty;
	logic    lit_done, lit_busy;

	// The front end owns the chunk state and writes literal bytes into the
	// buffer as the stretch grows.
	rle_front #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.data_byte  (data_byte),
		.stream_end (stream_end),
		.q_full     (q_full),
		.lit_done   (lit_done),
		.cmd_push   (cmd_push),
		.cmd        (cmd),
		.buf_wr     (buf_wr),
		.lit_busy   (lit_busy)
	);

	// Closed chunks wait here so the front keeps taking bytes while the
	// back end is busy sending.
	rle_cmd_q u_cmd_q (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (cmd_push),
		.wdata  (cmd),
		.pop    (q_pop),
		.rdata  (q_head),
		.full   (q_full),
		.empty  (q_empty)
	);

	// The back end holds the literal buffer and the output register.
	rle_back #(
		.MAX_CHUNK (MAX_CHUNK)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_empty       (q_empty),
		.q_head        (q_head),
		.q_pop         (q_pop),
		.buf_wr        (buf_wr),
		.lit_done      (lit_done),
		.result_valid  (result_valid),
		.result_stall  (result_stall),
		.out_byte      (out_byte),
		.is_header     (is_header),
		.last_of_burst (last_of_burst)
	);

	// A command is only pushed when the queue has room for it.
	a_queue_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_push |-> !q_full)
		else $error("command pushed into a full queue");

	// The literal buffer is never written while the back end still reads it.
	a_buffer_not_clobbered: assert property (@(posedge clk) disable iff (!arst_n)
		buf_wr.en |-> !lit_busy)
		else $error("literal buffer written while a stretch is being sent");

	// The back end only finishes a literal stretch that the front handed over.
	a_done_matches_busy: assert property (@(posedge clk) disable iff (!arst_n)
		lit_done |-> lit_busy)
		else $error("literal stretch finished with none outstanding");

	// A header is always followed by at least one data byte.
	a_header_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && is_header) |-> !last_of_burst)
		else $error("header marked as the last byte of a burst");

endmodule

`default_nettype wire
